// ===== rtl/crbd_pkg.sv =====
// Shared types and constants for the card read badge decoder.
`default_nettype none

package crbd_pkg;

  localparam int unsigned AsciiMaxLenDefault = 64;
  localparam int unsigned BadgeWidth         = 64;

  localparam logic [1:0] FmtAscii   = 2'd0;
  localparam logic [1:0] FmtRaw     = 2'd1;
  localparam logic [1:0] FmtWiegand = 2'd2;

  localparam logic [7:0] CharZero     = 8'h30;
  localparam logic [7:0] CharNine     = 8'h39;
  localparam logic [7:0] ByteCountMax = 8'hFF;
  localparam logic [7:0] RawMaxBits   = 8'd64;

  typedef struct packed {
    logic       start_of_record;
    logic [1:0] card_format;
    logic [7:0] record_length;
    logic       reverse_order;
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [BadgeWidth-1:0] acc;
    logic [1:0]            fmt;
    logic [7:0]            len;
    logic                  rev;
    logic [7:0]            seen;
    logic                  fault;
  } rec_state_t;

  typedef struct packed {
    logic                  decode_ok;
    logic [BadgeWidth-1:0] badge_value;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/crbd_if.sv =====
// Word channels: card data bytes in, decoded badges out.
`default_nettype none

interface crbd_in_if;
  logic       valid;
  logic       ready;
  logic       start_of_record;
  logic [1:0] card_format;
  logic [7:0] record_length;
  logic       reverse_order;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (
    output valid, start_of_record, card_format, record_length, reverse_order,
           data_byte, last_byte,
    input  ready
  );
  modport sink (
    input  valid, start_of_record, card_format, record_length, reverse_order,
           data_byte, last_byte,
    output ready
  );
endinterface

interface crbd_out_if;
  logic        valid;
  logic        ready;
  logic        decode_ok;
  logic [63:0] badge_value;

  modport source (output valid, decode_ok, badge_value, input ready);
  modport sink   (input valid, decode_ok, badge_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/crbd_step.sv =====
// Per-byte record update: header check, digit accumulation and raw bit placement.
`default_nettype none

module crbd_step #(
  parameter int unsigned MaxAsciiLen = crbd_pkg::AsciiMaxLenDefault
) (
  input  crbd_pkg::item_t      item_i,
  input  crbd_pkg::rec_state_t state_i,
  output crbd_pkg::rec_state_t state_o,
  output crbd_pkg::result_t    result_o
);

  localparam logic [7:0] MaxAsciiLenW = 8'(MaxAsciiLen);

  function automatic logic [7:0] flip8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = b[i];
    end
    return r;
  endfunction

  crbd_pkg::rec_state_t eff, upd;
  logic        hdr_ok;
  logic        is_digit;
  logic [3:0]  digit;
  logic [10:0] idx8;
  logic [10:0] remain;
  logic        raw_active;
  logic [3:0]  take;
  logic [7:0]  take_mask;
  logic [7:0]  rev_bits;
  logic [5:0]  rev_shift;
  logic [8:0]  need;
  logic        ok;

  always_comb begin
    eff = state_i;
    // a new record starts from a clean slate with the fresh header
    if (item_i.start_of_record) begin
      eff       = '0;
      eff.fmt   = item_i.card_format;
      eff.len   = item_i.record_length;
      eff.rev   = item_i.reverse_order;
    end
  end

  always_comb begin
    hdr_ok = 1'b0;
    if (eff.len != 8'd0) begin
      unique case (eff.fmt)
        crbd_pkg::FmtAscii:   hdr_ok = (eff.len <= MaxAsciiLenW);
        crbd_pkg::FmtRaw,
        crbd_pkg::FmtWiegand: hdr_ok = (eff.len <= crbd_pkg::RawMaxBits);
        default:              hdr_ok = 1'b0;
      endcase
    end
  end

  assign is_digit   = (item_i.data_byte >= crbd_pkg::CharZero) &&
                      (item_i.data_byte <= crbd_pkg::CharNine);
  assign digit      = 4'(item_i.data_byte - crbd_pkg::CharZero);
  assign idx8       = {eff.seen, 3'b000};
  assign raw_active = idx8 < {3'b000, eff.len};
  assign remain     = {3'b000, eff.len} - idx8;
  assign take       = (remain > 11'd8) ? 4'd8 : remain[3:0];
  assign take_mask  = 8'hFF >> (4'd8 - take);
  assign rev_bits   = flip8(item_i.data_byte) & take_mask;
  assign rev_shift  = {eff.seen[2:0], 3'b000};

  always_comb begin
    upd = eff;
    if (hdr_ok) begin
      if (eff.fmt == crbd_pkg::FmtAscii) begin
        if ({3'b000, eff.seen} < {3'b000, eff.len}) begin
          if (is_digit) begin
            // times ten as shift-add
            upd.acc = (eff.acc << 3) + (eff.acc << 1) + 64'(digit);
          end else begin
            upd.fault = 1'b1;
          end
        end
      end else if (raw_active) begin
        if (eff.rev) begin
          upd.acc = eff.acc | (64'(rev_bits) << rev_shift);
        end else begin
          upd.acc = (eff.acc << take) | 64'(item_i.data_byte >> (4'd8 - take));
        end
      end
    end
    // saturate the byte count
    if (eff.seen != crbd_pkg::ByteCountMax) begin
      upd.seen = eff.seen + 8'd1;
    end
  end

  assign need = (eff.fmt == crbd_pkg::FmtAscii) ? {1'b0, eff.len}
                                                : (({1'b0, eff.len} + 9'd7) >> 3);
  assign ok   = hdr_ok && !upd.fault && ({1'b0, upd.seen} >= need);

  assign result_o.decode_ok   = ok;
  assign result_o.badge_value = ok ? upd.acc : '0;

  // drop the record once its result is out
  assign state_o = item_i.last_byte ? '0 : upd;

endmodule

`default_nettype wire

// ===== rtl/card_read_badge_decoder_core.sv =====
// Card read badge decoder: top level with input stage, record state and result register.
//
// Usage: card data arrives one byte per word on in_i, with start_of_record on the
// first byte (header fields card_format, record_length and reverse_order are
// sampled there) and last_byte on the final one. Each record yields one word on
// out_o carrying decode_ok and badge_value; badge_value is zero on any fault.
// An accepted last byte passes through the input register, then the record update into
// the result register, before it is presented on out_o.
// Throughput: one byte per cycle while no final byte waits on a stalled out_o; the
// record update is a combinational shift-add times ten, a shift of at most eight bits,
// or in reverse order a placement of the flipped byte at a byte offset.
// Reset clears the record state, the input stage and the result register, so
// bytes arriving without a start_of_record belong to a record with a zero
// length and give decode_ok 0.
// When out_o stalls, non-final bytes keep flowing into the record state; a
// final byte waits in the input stage until the result register is free.
`default_nettype none

module card_read_badge_decoder_core #(
  parameter int unsigned MaxAsciiLen = crbd_pkg::AsciiMaxLenDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  crbd_in_if.sink     in_i,
  crbd_out_if.source  out_o
);

  crbd_pkg::item_t      item_q;
  logic                 item_valid_q;
  crbd_pkg::rec_state_t state_q, state_d;
  crbd_pkg::result_t    result_d, out_q;
  logic                 out_valid_q;
  logic                 advance;
  logic                 in_ready;

  assign advance  = item_valid_q && (!item_q.last_byte || !out_valid_q || out_o.ready);
  assign in_ready = !item_valid_q || advance;
  assign in_i.ready = in_ready;

  crbd_step #(
    .MaxAsciiLen(MaxAsciiLen)
  ) u_step (
    .item_i  (item_q),
    .state_i (state_q),
    .state_o (state_d),
    .result_o(result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready) begin
      item_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      item_q.start_of_record <= in_i.start_of_record;
      item_q.card_format     <= in_i.card_format;
      item_q.record_length   <= in_i.record_length;
      item_q.reverse_order   <= in_i.reverse_order;
      item_q.data_byte       <= in_i.data_byte;
      item_q.last_byte       <= in_i.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && item_q.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && item_q.last_byte) begin
      out_q <= result_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.decode_ok   = out_q.decode_ok;
  assign out_o.badge_value = out_q.badge_value;

  // a final byte always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && item_q.last_byte |=> out_valid_q)
    else $error("final byte did not produce a result word");

  // the record is dropped after its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && item_q.last_byte |=> state_q.len == 8'd0 && state_q.seen == 8'd0 &&
                                    !state_q.fault)
    else $error("record state not cleared after final byte");

  // a faulty record carries a zero badge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.decode_ok |-> out_q.badge_value == '0)
    else $error("nonzero badge on a failed decode");

endmodule

`default_nettype wire
